### src/gp3n_pkg.sv
// Shared types, constants and arithmetic helpers for the 3D grid prolongation block.
`timescale 1ns / 1ps
package gp3n_pkg;

	// Geometry
	localparam int IMAGES    = 4;
	localparam int DIM_MAX   = 64;
	localparam int TAPS      = 2 * IMAGES;
	localparam int PAD       = DIM_MAX + 2 * IMAGES;
	localparam int PLANE     = PAD * PAD;
	localparam int TAP_W     = $clog2(TAPS);
	localparam int POS_W     = $clog2(PAD + 1);
	localparam int ADDR_W    = $clog2(TAPS * PLANE);
	localparam int AX_DEPTH  = TAPS * TAPS;
	localparam int AX_W      = $clog2(AX_DEPTH);

	// Field and datapath widths
	localparam int SIZE_W    = 7;
	localparam int FINE_W    = 7;
	localparam int SMP_W     = 16;
	localparam int COEF_W    = 16;
	localparam int VAL_W     = 32;
	localparam int PROD_W    = COEF_W + VAL_W;
	localparam int ACC_W     = PROD_W + $clog2(TAPS) + 1;
	localparam int CONTRIB_W = 48;
	localparam int ODD_N     = 12;
	localparam int ODD_W     = ODD_N * COEF_W;

	// Register port
	localparam int CFG_W     = 64;
	localparam int REG_N     = 8;
	localparam int REG_IDX_W = $clog2(REG_N);
	localparam int PADDR_W   = REG_IDX_W + 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_EVEN     = 3'd0,
		REG_ODD_LOW  = 3'd1,
		REG_ODD_MID  = 3'd2,
		REG_ODD_HIGH = 3'd3,
		REG_SCALE    = 3'd4,
		REG_SIZE_X   = 3'd5,
		REG_SIZE_Y   = 3'd6,
		REG_SIZE_Z   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		DEST_AX  = 2'd0,
		DEST_BY  = 2'd1,
		DEST_OUT = 2'd2
	} dest_t;

	typedef enum logic [1:0] {
		SRC_PLANE = 2'd0,
		SRC_AX    = 2'd1,
		SRC_BY    = 2'd2
	} src_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_re;
		logic signed [SMP_W-1:0] sample_im;
	} sample_t;

	typedef struct packed {
		logic [FINE_W-1:0]    fine_x;
		logic [FINE_W-1:0]    fine_y;
		logic [FINE_W-1:0]    fine_z;
		logic [CONTRIB_W-1:0] contribution;
		logic                 run_last;
	} point_t;

	// One tap operation issued by the sequencer
	typedef struct packed {
		logic                     valid;
		src_t                     src;
		logic [TAP_W-1:0]         plane;
		logic [POS_W-1:0]         row;
		logic [POS_W-1:0]         col;
		logic [AX_W-1:0]          ax_addr;
		logic [TAP_W-1:0]         by_idx;
		logic signed [COEF_W-1:0] coeff;
		logic                     first;
		logic                     last;
		dest_t                    dest;
		logic [AX_W-1:0]          dest_idx;
	} seq_op_t;

	// Operands into the multiply-accumulate unit
	typedef struct packed {
		logic                     valid;
		logic                     first;
		logic                     last;
		dest_t                    dest;
		logic [AX_W-1:0]          dest_idx;
		logic signed [COEF_W-1:0] coeff;
		logic signed [VAL_W-1:0]  re;
		logic signed [VAL_W-1:0]  im;
	} mac_op_t;

	typedef struct packed {
		logic                    valid;
		dest_t                   dest;
		logic [AX_W-1:0]         dest_idx;
		logic signed [VAL_W-1:0] re;
		logic signed [VAL_W-1:0] im;
	} mac_res_t;

	typedef struct packed {
		logic idle;
		logic xpass;
		logic ypass;
		logic zwait;
	} seq_stat_t;

	typedef struct packed {
		logic [FINE_W-1:0] fine_x;
		logic [FINE_W-1:0] fine_y;
		logic [FINE_W-1:0] fine_z;
		logic              run_last;
	} pt_tag_t;

	// Coefficient of tap k for the even or odd phase
	function automatic logic signed [COEF_W-1:0] coeff_sel(
		input logic                     phase,
		input logic [TAP_W-1:0]         k,
		input logic signed [COEF_W-1:0] even,
		input logic [ODD_W-1:0]         odd
	);
		logic signed [COEF_W-1:0] r;
		if (!phase) begin
			r = (k == TAP_W'(IMAGES - 1)) ? even : '0;
		end else begin
			r = odd[COEF_W * int'(k) +: COEF_W];
		end
		return r;
	endfunction

	// Round half up from 29 to 15 fractional bits, saturate to 32 bits
	function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W:0] w;
		logic signed [ACC_W:0] r;
		logic signed [VAL_W-1:0] o;
		w = (ACC_W + 1)'(v) + (ACC_W + 1)'(8192);
		r = w >>> 14;
		if ((&r[ACC_W:VAL_W-1]) || !(|r[ACC_W:VAL_W-1])) begin
			o = r[VAL_W-1:0];
		end else if (r[ACC_W]) begin
			o = {1'b1, {(VAL_W - 1){1'b0}}};
		end else begin
			o = {1'b0, {(VAL_W - 1){1'b1}}};
		end
		return o;
	endfunction

endpackage

### src/gp3n_mac.sv
// Dual-lane multiply-accumulate unit with rounding and saturation, shared by all passes.
`timescale 1ns / 1ps
module gp3n_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  gp3n_pkg::mac_op_t  op,
	output gp3n_pkg::mac_res_t res,
	output logic               busy
);

	logic                                 v_s2;
	logic                                 first_s2;
	logic                                 last_s2;
	gp3n_pkg::dest_t                      dest_s2;
	logic [gp3n_pkg::AX_W-1:0]            idx_s2;
	logic signed [gp3n_pkg::PROD_W-1:0]   prod_re_s2;
	logic signed [gp3n_pkg::PROD_W-1:0]   prod_im_s2;

	logic                                 v_s3;
	gp3n_pkg::dest_t                      dest_s3;
	logic [gp3n_pkg::AX_W-1:0]            idx_s3;
	logic signed [gp3n_pkg::ACC_W-1:0]    acc_re_s3;
	logic signed [gp3n_pkg::ACC_W-1:0]    acc_im_s3;

	logic                                 v_s4;
	gp3n_pkg::dest_t                      dest_s4;
	logic [gp3n_pkg::AX_W-1:0]            idx_s4;
	logic signed [gp3n_pkg::VAL_W-1:0]    re_s4;
	logic signed [gp3n_pkg::VAL_W-1:0]    im_s4;

	// Track which stages hold work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= op.valid;
			v_s3 <= v_s2 && last_s2;
			v_s4 <= v_s3;
		end
	end

	// Multiply coefficient by both lanes
	always_ff @(posedge clk) begin
		if (op.valid) begin
			first_s2   <= op.first;
			last_s2    <= op.last;
			dest_s2    <= op.dest;
			idx_s2     <= op.dest_idx;
			prod_re_s2 <= gp3n_pkg::PROD_W'(op.coeff) * gp3n_pkg::PROD_W'(op.re);
			prod_im_s2 <= gp3n_pkg::PROD_W'(op.coeff) * gp3n_pkg::PROD_W'(op.im);
		end
	end

	// Accumulate, restart on the first tap of a sum
	always_ff @(posedge clk) begin
		if (v_s2) begin
			dest_s3 <= dest_s2;
			idx_s3  <= idx_s2;
			if (first_s2) begin
				acc_re_s3 <= gp3n_pkg::ACC_W'(prod_re_s2);
				acc_im_s3 <= gp3n_pkg::ACC_W'(prod_im_s2);
			end else begin
				acc_re_s3 <= acc_re_s3 + gp3n_pkg::ACC_W'(prod_re_s2);
				acc_im_s3 <= acc_im_s3 + gp3n_pkg::ACC_W'(prod_im_s2);
			end
		end
	end

	// Round and saturate a finished sum
	always_ff @(posedge clk) begin
		if (v_s3) begin
			dest_s4 <= dest_s3;
			idx_s4  <= idx_s3;
			re_s4   <= gp3n_pkg::round_sat(acc_re_s3);
			im_s4   <= gp3n_pkg::round_sat(acc_im_s3);
		end
	end

	assign res.valid    = v_s4;
	assign res.dest     = dest_s4;
	assign res.dest_idx = idx_s4;
	assign res.re       = re_s4;
	assign res.im       = im_s4;
	assign busy         = v_s2 || v_s3 || v_s4;

endmodule

### src/gp3n_norm.sv
// Scaled squared magnitude unit built around one shared 33x33 multiplier.
`timescale 1ns / 1ps
module gp3n_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [gp3n_pkg::VAL_W-1:0] re,
	input  logic signed [gp3n_pkg::VAL_W-1:0] im,
	input  logic [31:0]                       scale,
	input  gp3n_pkg::pt_tag_t                 tag,
	input  logic                              out_free,
	output logic                              load,
	output gp3n_pkg::point_t                  item
);

	localparam int MUL_W  = 33;
	localparam int SUM_W  = gp3n_pkg::CONTRIB_W + 4;

	typedef enum logic [7:0] {
		N_IDLE = 8'b0000_0001,
		N_RR   = 8'b0000_0010,
		N_II   = 8'b0000_0100,
		N_SUM  = 8'b0000_1000,
		N_LO   = 8'b0001_0000,
		N_HI   = 8'b0010_0000,
		N_FIN  = 8'b0100_0000,
		N_HOLD = 8'b1000_0000
	} norm_st_t;

	norm_st_t                          st_q;
	logic signed [gp3n_pkg::VAL_W-1:0] re_q;
	logic signed [gp3n_pkg::VAL_W-1:0] im_q;
	gp3n_pkg::pt_tag_t                 tag_q;
	logic [63:0]                       prod_q;
	logic [63:0]                       mag_q;
	logic [63:0]                       plo_q;
	logic [gp3n_pkg::CONTRIB_W-1:0]    contrib_q;

	logic signed [MUL_W-1:0]           mul_a;
	logic signed [MUL_W-1:0]           mul_b;
	logic signed [2*MUL_W-1:0]         mul_p;
	logic [SUM_W-1:0]                  sum;

	// Select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			N_RR: begin
				mul_a = {re_q[gp3n_pkg::VAL_W-1], re_q};
				mul_b = {re_q[gp3n_pkg::VAL_W-1], re_q};
			end
			N_II: begin
				mul_a = {im_q[gp3n_pkg::VAL_W-1], im_q};
				mul_b = {im_q[gp3n_pkg::VAL_W-1], im_q};
			end
			N_LO: begin
				mul_a = {1'b0, mag_q[31:0]};
				mul_b = {1'b0, scale};
			end
			N_HI: begin
				mul_a = {1'b0, mag_q[63:32]};
				mul_b = {1'b0, scale};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Combine the high and low partial products with rounding
	assign sum = SUM_W'({prod_q[29:0], 18'b0}) + SUM_W'(plo_q >> 14) + SUM_W'(plo_q[13]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
		end else begin
			case (st_q)
				N_IDLE:  if (start) st_q <= N_RR;
				N_RR:    st_q <= N_II;
				N_II:    st_q <= N_SUM;
				N_SUM:   st_q <= N_LO;
				N_LO:    st_q <= N_HI;
				N_HI:    st_q <= N_FIN;
				N_FIN:   st_q <= N_HOLD;
				N_HOLD:  if (out_free) st_q <= N_IDLE;
				default: st_q <= N_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (st_q == N_IDLE && start) begin
			re_q  <= re;
			im_q  <= im;
			tag_q <= tag;
		end
		if (st_q == N_RR || st_q == N_II || st_q == N_LO || st_q == N_HI) begin
			prod_q <= mul_p[63:0];
		end
		if (st_q == N_II) mag_q <= prod_q;
		if (st_q == N_SUM) mag_q <= mag_q + prod_q;
		if (st_q == N_HI) plo_q <= prod_q;
		if (st_q == N_FIN) begin
			if (prod_q >= 64'd1073741824 || sum[SUM_W-1:gp3n_pkg::CONTRIB_W] != '0) begin
				contrib_q <= '1;
			end else begin
				contrib_q <= sum[gp3n_pkg::CONTRIB_W-1:0];
			end
		end
	end

	assign load              = (st_q == N_HOLD) && out_free;
	assign item.fine_x       = tag_q.fine_x;
	assign item.fine_y       = tag_q.fine_y;
	assign item.fine_z       = tag_q.fine_z;
	assign item.contribution = contrib_q;
	assign item.run_last     = tag_q.run_last;

endmodule

### src/gp3n_seq.sv
// Sequencer that walks the x, y and z filter passes of one coarse cell tap by tap.
`timescale 1ns / 1ps
module gp3n_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [gp3n_pkg::TAP_W-1:0]          pbase,
	input  logic [gp3n_pkg::POS_W-1:0]          rbase,
	input  logic [gp3n_pkg::POS_W-1:0]          cbase,
	input  logic [gp3n_pkg::POS_W-1:0]          cx,
	input  logic [gp3n_pkg::POS_W-1:0]          cy,
	input  logic [gp3n_pkg::POS_W-1:0]          cz,
	input  logic signed [gp3n_pkg::COEF_W-1:0]  even,
	input  logic [gp3n_pkg::ODD_W-1:0]          odd,
	input  logic                                drain_busy,
	input  logic                                norm_done,
	output gp3n_pkg::seq_op_t                   op,
	output gp3n_pkg::pt_tag_t                   tag,
	output gp3n_pkg::seq_stat_t                 stat
);

	localparam logic [gp3n_pkg::TAP_W-1:0] LAST = gp3n_pkg::TAP_W'(gp3n_pkg::TAPS - 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b000_0001,
		ST_XP   = 7'b000_0010,
		ST_XD   = 7'b000_0100,
		ST_YP   = 7'b000_1000,
		ST_YD   = 7'b001_0000,
		ST_ZP   = 7'b010_0000,
		ST_ZW   = 7'b100_0000
	} seq_st_t;

	seq_st_t                    st_q;
	logic                       fx_q;
	logic                       fy_q;
	logic                       fz_q;
	logic [gp3n_pkg::TAP_W-1:0] a_q;
	logic [gp3n_pkg::TAP_W-1:0] b_q;
	logic [gp3n_pkg::TAP_W-1:0] k_q;
	logic [gp3n_pkg::TAP_W:0]   psum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			fx_q <= 1'b0;
			fy_q <= 1'b0;
			fz_q <= 1'b0;
			a_q  <= '0;
			b_q  <= '0;
			k_q  <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q <= ST_XP;
						fx_q <= 1'b0;
						fy_q <= 1'b0;
						fz_q <= 1'b0;
						a_q  <= '0;
						b_q  <= '0;
						k_q  <= '0;
					end
				end
				// Tap k over window row a, column b
				ST_XP: begin
					k_q <= (k_q == LAST) ? '0 : k_q + 1'b1;
					if (k_q == LAST) begin
						b_q <= (b_q == LAST) ? '0 : b_q + 1'b1;
						if (b_q == LAST) begin
							a_q <= (a_q == LAST) ? '0 : a_q + 1'b1;
							if (a_q == LAST) st_q <= ST_XD;
						end
					end
				end
				ST_XD: begin
					if (!drain_busy) st_q <= ST_YP;
				end
				ST_YP: begin
					k_q <= (k_q == LAST) ? '0 : k_q + 1'b1;
					if (k_q == LAST) begin
						b_q <= (b_q == LAST) ? '0 : b_q + 1'b1;
						if (b_q == LAST) st_q <= ST_YD;
					end
				end
				ST_YD: begin
					if (!drain_busy) st_q <= ST_ZP;
				end
				ST_ZP: begin
					k_q <= (k_q == LAST) ? '0 : k_q + 1'b1;
					if (k_q == LAST) st_q <= ST_ZW;
				end
				// Advance the phase counters once the point has left
				ST_ZW: begin
					if (norm_done) begin
						if (!fz_q) begin
							fz_q <= 1'b1;
							st_q <= ST_ZP;
						end else begin
							fz_q <= 1'b0;
							if (!fy_q) begin
								fy_q <= 1'b1;
								st_q <= ST_YP;
							end else begin
								fy_q <= 1'b0;
								if (!fx_q) begin
									fx_q <= 1'b1;
									st_q <= ST_XP;
								end else begin
									fx_q <= 1'b0;
									st_q <= ST_IDLE;
								end
							end
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Ring index of the x-plane for tap k
	assign psum = {1'b0, pbase} + {1'b0, k_q};

	// Build the tap operation of the current step
	always_comb begin
		op       = '0;
		op.first = (k_q == '0);
		op.last  = (k_q == LAST);
		op.plane = (psum >= (gp3n_pkg::TAP_W + 1)'(gp3n_pkg::TAPS))
			? gp3n_pkg::TAP_W'(psum - (gp3n_pkg::TAP_W + 1)'(gp3n_pkg::TAPS))
			: psum[gp3n_pkg::TAP_W-1:0];
		op.row   = rbase + gp3n_pkg::POS_W'(a_q);
		op.col   = cbase + gp3n_pkg::POS_W'(b_q);
		op.by_idx = k_q;
		case (st_q)
			ST_XP: begin
				op.valid    = 1'b1;
				op.src      = gp3n_pkg::SRC_PLANE;
				op.coeff    = gp3n_pkg::coeff_sel(fx_q, k_q, even, odd);
				op.dest     = gp3n_pkg::DEST_AX;
				op.dest_idx = gp3n_pkg::AX_W'(int'(a_q) * gp3n_pkg::TAPS + int'(b_q));
			end
			ST_YP: begin
				op.valid    = 1'b1;
				op.src      = gp3n_pkg::SRC_AX;
				op.ax_addr  = gp3n_pkg::AX_W'(int'(k_q) * gp3n_pkg::TAPS + int'(b_q));
				op.coeff    = gp3n_pkg::coeff_sel(fy_q, k_q, even, odd);
				op.dest     = gp3n_pkg::DEST_BY;
				op.dest_idx = gp3n_pkg::AX_W'(b_q);
			end
			ST_ZP: begin
				op.valid    = 1'b1;
				op.src      = gp3n_pkg::SRC_BY;
				op.coeff    = gp3n_pkg::coeff_sel(fz_q, k_q, even, odd);
				op.dest     = gp3n_pkg::DEST_OUT;
			end
			default: begin
				op.valid = 1'b0;
			end
		endcase
	end

	assign tag.fine_x   = gp3n_pkg::FINE_W'({cx, fx_q});
	assign tag.fine_y   = gp3n_pkg::FINE_W'({cy, fy_q});
	assign tag.fine_z   = gp3n_pkg::FINE_W'({cz, fz_q});
	assign tag.run_last = fx_q && fy_q && fz_q;

	assign stat.idle  = (st_q == ST_IDLE);
	assign stat.xpass = (st_q == ST_XP) || (st_q == ST_XD);
	assign stat.ypass = (st_q == ST_YP) || (st_q == ST_YD);
	assign stat.zwait = (st_q == ST_ZW);

endmodule

### src/grid_prolong_3d_norm.sv
// Top level of the streamed 2x 3D prolongation with scaled squared magnitude output.
//
// Coarse samples of the padded grid enter on the sample channel in raster order
// (x slowest, z fastest); each transfer takes one complex Q1.15 sample. Fine
// points leave on the point channel: fine indices, a 48-bit saturated
// contribution and run_last on the eighth point of a cell.
// A sample that does not complete a window is taken without a stall and gives no
// points. A sample that completes a window keeps sample_stall high until the last
// point of its cell is loaded: one multiply-accumulate lane pair works one tap
// per cycle while taps are issued, 512 window reads from the plane memory per x
// pass, 64 taps per y pass and 8 per z pass, a drain after each x and y pass,
// and for each of the eight points a magnitude step through one shared multiplier
// once its z sum leaves the pipeline.
// The last point sits in an output register, so the next sample is taken while
// it waits for the receiver; while point_stall is high the point holds and the
// sequencer waits before it produces another.
// Reset returns the position to the start of a frame and the registers to their
// defaults. The plane memory is not cleared; every window entry is written by
// the stream before it is read. Writing a size register restarts the frame.
`timescale 1ns / 1ps
module grid_prolong_3d_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gp3n_pkg::PADDR_W-1:0]      paddr,
	input  logic [gp3n_pkg::CFG_W-1:0]        pwdata,
	output logic [gp3n_pkg::CFG_W-1:0]        prdata,
	output logic                              pready,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  gp3n_pkg::sample_t                 sample,
	output logic                              point_valid,
	input  logic                              point_stall,
	output gp3n_pkg::point_t                  point
);

	localparam int PW = gp3n_pkg::POS_W;
	localparam int TW = gp3n_pkg::TAP_W;

	// Configuration registers
	logic [gp3n_pkg::COEF_W-1:0]  even_q;
	logic [63:0]                  odd_lo_q;
	logic [63:0]                  odd_mid_q;
	logic [63:0]                  odd_hi_q;
	logic [31:0]                  scale_q;
	logic [gp3n_pkg::SIZE_W-1:0]  size_x_q;
	logic [gp3n_pkg::SIZE_W-1:0]  size_y_q;
	logic [gp3n_pkg::SIZE_W-1:0]  size_z_q;
	logic                         cfg_we;
	gp3n_pkg::reg_idx_t           cfg_idx;
	logic                         size_we;

	// Position
	logic [PW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [TW-1:0] wp_q;
	logic [PW-1:0] ex, ey, ez;
	logic          wrap;
	logic [PW-1:0] px, py, pz;
	logic [TW-1:0] wp;
	logic [PW:0]   px1, py1, pz1;
	logic [TW:0]   wp1;
	logic [PW-1:0] nx, ny, nz;
	logic [TW-1:0] nwp;
	logic          acc_in;
	logic          interior;
	logic [TW:0]   pb1;

	// Window bases for the running cell
	logic [TW-1:0] pbase_q;
	logic [PW-1:0] rbase_q, cbase_q, cx_q, cy_q, cz_q;

	// Sequencer, pipeline and units
	gp3n_pkg::seq_op_t   op;
	gp3n_pkg::pt_tag_t   tag;
	gp3n_pkg::seq_stat_t seq_stat;
	gp3n_pkg::mac_op_t   mac_in;
	gp3n_pkg::mac_res_t  mac_res;
	logic                mac_busy;
	logic                drain_busy;
	logic                norm_load;
	gp3n_pkg::point_t    norm_item;
	logic                out_free;

	logic                          op_v_s1;
	gp3n_pkg::src_t                src_s1;
	logic signed [gp3n_pkg::COEF_W-1:0] coeff_s1;
	logic                          first_s1;
	logic                          last_s1;
	gp3n_pkg::dest_t               dest_s1;
	logic [gp3n_pkg::AX_W-1:0]     idx_s1;

	// Memories and the y-pass row
	logic [31:0] plane_mem [gp3n_pkg::TAPS * gp3n_pkg::PLANE];
	logic [31:0] plane_rd_s1;
	logic [63:0] ax_mem [gp3n_pkg::AX_DEPTH];
	logic [63:0] ax_rd_s1;
	logic signed [gp3n_pkg::VAL_W-1:0] by_re_q [gp3n_pkg::TAPS];
	logic signed [gp3n_pkg::VAL_W-1:0] by_im_q [gp3n_pkg::TAPS];
	logic [63:0] by_rd_s1;
	logic [gp3n_pkg::ADDR_W-1:0] wr_addr;
	logic [gp3n_pkg::ADDR_W-1:0] rd_addr;
	logic                        ax_we;
	logic                        by_we;

	logic                    point_valid_q;
	gp3n_pkg::point_t        point_q;

	function automatic logic [PW-1:0] eff_size(input logic [gp3n_pkg::SIZE_W-1:0] s);
		logic [PW-1:0] r;
		if (s == '0) begin
			r = PW'(1);
		end else if (int'(s) > gp3n_pkg::DIM_MAX) begin
			r = PW'(gp3n_pkg::DIM_MAX);
		end else begin
			r = PW'(s);
		end
		return r;
	endfunction

	// Register port
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = gp3n_pkg::reg_idx_t'(paddr[gp3n_pkg::PADDR_W-1:3]);
	assign size_we = cfg_we && (cfg_idx == gp3n_pkg::REG_SIZE_X
		|| cfg_idx == gp3n_pkg::REG_SIZE_Y || cfg_idx == gp3n_pkg::REG_SIZE_Z);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_q    <= 16'd16384;
			odd_lo_q  <= '0;
			odd_mid_q <= '0;
			odd_hi_q  <= '0;
			scale_q   <= 32'd65536;
			size_x_q  <= 7'd64;
			size_y_q  <= 7'd64;
			size_z_q  <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_idx)
				gp3n_pkg::REG_EVEN:     even_q    <= pwdata[gp3n_pkg::COEF_W-1:0];
				gp3n_pkg::REG_ODD_LOW:  odd_lo_q  <= pwdata;
				gp3n_pkg::REG_ODD_MID:  odd_mid_q <= pwdata;
				gp3n_pkg::REG_ODD_HIGH: odd_hi_q  <= pwdata;
				gp3n_pkg::REG_SCALE:    scale_q   <= pwdata[31:0];
				gp3n_pkg::REG_SIZE_X:   size_x_q  <= pwdata[gp3n_pkg::SIZE_W-1:0];
				gp3n_pkg::REG_SIZE_Y:   size_y_q  <= pwdata[gp3n_pkg::SIZE_W-1:0];
				gp3n_pkg::REG_SIZE_Z:   size_z_q  <= pwdata[gp3n_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			gp3n_pkg::REG_EVEN:     prdata = gp3n_pkg::CFG_W'(even_q);
			gp3n_pkg::REG_ODD_LOW:  prdata = odd_lo_q;
			gp3n_pkg::REG_ODD_MID:  prdata = odd_mid_q;
			gp3n_pkg::REG_ODD_HIGH: prdata = odd_hi_q;
			gp3n_pkg::REG_SCALE:    prdata = gp3n_pkg::CFG_W'(scale_q);
			gp3n_pkg::REG_SIZE_X:   prdata = gp3n_pkg::CFG_W'(size_x_q);
			gp3n_pkg::REG_SIZE_Y:   prdata = gp3n_pkg::CFG_W'(size_y_q);
			gp3n_pkg::REG_SIZE_Z:   prdata = gp3n_pkg::CFG_W'(size_z_q);
			default:                prdata = '0;
		endcase
	end

	// Padded extents, restart position out of frame
	assign ex   = eff_size(size_x_q) + PW'(gp3n_pkg::TAPS);
	assign ey   = eff_size(size_y_q) + PW'(gp3n_pkg::TAPS);
	assign ez   = eff_size(size_z_q) + PW'(gp3n_pkg::TAPS);
	assign wrap = (pos_x_q >= ex) || (pos_y_q >= ey) || (pos_z_q >= ez);
	assign px   = wrap ? '0 : pos_x_q;
	assign py   = wrap ? '0 : pos_y_q;
	assign pz   = wrap ? '0 : pos_z_q;
	assign wp   = wrap ? '0 : wp_q;

	assign acc_in   = sample_valid && !sample_stall;
	assign interior = (px >= PW'(gp3n_pkg::TAPS)) && (py >= PW'(gp3n_pkg::TAPS))
		&& (pz >= PW'(gp3n_pkg::TAPS));

	// Advance the raster position and the plane ring
	always_comb begin
		pz1 = {1'b0, pz} + 1'b1;
		py1 = {1'b0, py} + 1'b1;
		px1 = {1'b0, px} + 1'b1;
		wp1 = {1'b0, wp} + 1'b1;
		nx  = px;
		ny  = py;
		nz  = pz1[PW-1:0];
		nwp = wp;
		if (pz1 >= {1'b0, ez}) begin
			nz = '0;
			ny = py1[PW-1:0];
			if (py1 >= {1'b0, ey}) begin
				ny  = '0;
				nx  = px1[PW-1:0];
				nwp = (wp1 >= (TW + 1)'(gp3n_pkg::TAPS)) ? '0 : wp1[TW-1:0];
				if (px1 >= {1'b0, ex}) begin
					nx  = '0;
					nwp = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			wp_q    <= '0;
		end else if (size_we) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			wp_q    <= '0;
		end else if (acc_in) begin
			pos_x_q <= nx;
			pos_y_q <= ny;
			pos_z_q <= nz;
			wp_q    <= nwp;
		end
	end

	// Latch the window origin of a completed cell
	assign pb1 = {1'b0, wp} + 1'b1;

	always_ff @(posedge clk) begin
		if (acc_in && interior) begin
			pbase_q <= (pb1 >= (TW + 1)'(gp3n_pkg::TAPS)) ? '0 : pb1[TW-1:0];
			rbase_q <= py - PW'(gp3n_pkg::TAPS - 1);
			cbase_q <= pz - PW'(gp3n_pkg::TAPS - 1);
			cx_q    <= px - PW'(gp3n_pkg::TAPS);
			cy_q    <= py - PW'(gp3n_pkg::TAPS);
			cz_q    <= pz - PW'(gp3n_pkg::TAPS);
		end
	end

	gp3n_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (acc_in && interior),
		.pbase      (pbase_q),
		.rbase      (rbase_q),
		.cbase      (cbase_q),
		.cx         (cx_q),
		.cy         (cy_q),
		.cz         (cz_q),
		.even       (even_q),
		.odd        ({odd_hi_q, odd_mid_q, odd_lo_q}),
		.drain_busy (drain_busy),
		.norm_done  (norm_load),
		.op         (op),
		.tag        (tag),
		.stat       (seq_stat)
	);

	assign sample_stall = !seq_stat.idle;
	assign drain_busy   = op_v_s1 || mac_busy;

	// Plane store: write the incoming sample, read window taps
	assign wr_addr = gp3n_pkg::ADDR_W'(int'(wp) * gp3n_pkg::PLANE
		+ int'(py) * gp3n_pkg::PAD + int'(pz));
	assign rd_addr = gp3n_pkg::ADDR_W'(int'(op.plane) * gp3n_pkg::PLANE
		+ int'(op.row) * gp3n_pkg::PAD + int'(op.col));

	always_ff @(posedge clk) begin
		if (acc_in) begin
			plane_mem[wr_addr] <= {sample.sample_im, sample.sample_re};
		end
		if (op.valid && op.src == gp3n_pkg::SRC_PLANE) begin
			plane_rd_s1 <= plane_mem[rd_addr];
		end
	end

	// x-pass results
	assign ax_we = mac_res.valid && mac_res.dest == gp3n_pkg::DEST_AX;

	always_ff @(posedge clk) begin
		if (ax_we) begin
			ax_mem[mac_res.dest_idx] <= {mac_res.im, mac_res.re};
		end
		if (op.valid && op.src == gp3n_pkg::SRC_AX) begin
			ax_rd_s1 <= ax_mem[op.ax_addr];
		end
	end

	// y-pass results
	assign by_we = mac_res.valid && mac_res.dest == gp3n_pkg::DEST_BY;

	always_ff @(posedge clk) begin
		if (by_we) begin
			by_re_q[mac_res.dest_idx[TW-1:0]] <= mac_res.re;
			by_im_q[mac_res.dest_idx[TW-1:0]] <= mac_res.im;
		end
		if (op.valid && op.src == gp3n_pkg::SRC_BY) begin
			by_rd_s1 <= {by_im_q[op.by_idx], by_re_q[op.by_idx]};
		end
	end

	// Operand stage alongside the memory reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_v_s1 <= 1'b0;
		end else begin
			op_v_s1 <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op.valid) begin
			src_s1   <= op.src;
			coeff_s1 <= op.coeff;
			first_s1 <= op.first;
			last_s1  <= op.last;
			dest_s1  <= op.dest;
			idx_s1   <= op.dest_idx;
		end
	end

	always_comb begin
		mac_in.valid    = op_v_s1;
		mac_in.first    = first_s1;
		mac_in.last     = last_s1;
		mac_in.dest     = dest_s1;
		mac_in.dest_idx = idx_s1;
		mac_in.coeff    = coeff_s1;
		case (src_s1)
			gp3n_pkg::SRC_PLANE: begin
				mac_in.re = gp3n_pkg::VAL_W'(signed'(plane_rd_s1[15:0]));
				mac_in.im = gp3n_pkg::VAL_W'(signed'(plane_rd_s1[31:16]));
			end
			gp3n_pkg::SRC_AX: begin
				mac_in.re = ax_rd_s1[31:0];
				mac_in.im = ax_rd_s1[63:32];
			end
			gp3n_pkg::SRC_BY: begin
				mac_in.re = by_rd_s1[31:0];
				mac_in.im = by_rd_s1[63:32];
			end
			default: begin
				mac_in.re = '0;
				mac_in.im = '0;
			end
		endcase
	end

	gp3n_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_in),
		.res    (mac_res),
		.busy   (mac_busy)
	);

	gp3n_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mac_res.valid && mac_res.dest == gp3n_pkg::DEST_OUT),
		.re       (mac_res.re),
		.im       (mac_res.im),
		.scale    (scale_q),
		.tag      (tag),
		.out_free (out_free),
		.load     (norm_load),
		.item     (norm_item)
	);

	// Output register: hold while stalled, drop after transfer
	assign out_free = !point_valid_q || !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid_q <= 1'b0;
		end else if (norm_load) begin
			point_valid_q <= 1'b1;
		end else if (!point_stall) begin
			point_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (norm_load) begin
			point_q <= norm_item;
		end
	end

	assign point_valid = point_valid_q;
	assign point       = point_q;

	a_ax_write_in_xpass: assert property (@(posedge clk) disable iff (!arst_n)
		ax_we |-> seq_stat.xpass)
		else $error("x-pass result written outside the x pass");

	a_by_write_in_ypass: assert property (@(posedge clk) disable iff (!arst_n)
		by_we |-> seq_stat.ypass)
		else $error("y-pass result written outside the y pass");

	a_out_in_zwait: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_res.valid && mac_res.dest == gp3n_pkg::DEST_OUT) |-> seq_stat.zwait)
		else $error("point value produced while sequencer not waiting");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |-> !drain_busy)
		else $error("sample transfer while arithmetic still busy");

endmodule
